### rtl/rtc_pkg.sv
// Shared types, constants and the multiply microprogram of the closest-hit intersector.
package rtc_pkg;

  localparam int CHUNK_BITS     = 16;
  localparam int T_BITS         = 31;
  localparam int BARY_BITS      = 17;
  localparam int PARAM_BITS     = 16;
  localparam int DET_EPS_BITS   = 62;
  localparam int CFG_DATA_BITS  = 62;
  localparam int CFG_IDX_BITS   = 3;
  localparam int UPC_BITS       = 5;
  localparam int DIV_STEPS_T    = 31;
  localparam int DIV_STEPS_BARY = 17;
  localparam int DIR_X_RESET    = 4096;

  localparam logic [T_BITS-1:0]    T_MAX   = 31'h7FFF_FFFF;
  localparam logic [BARY_BITS-1:0] ONE_Q16 = 17'd65536;

  localparam logic [UPC_BITS-1:0] UOP_LAST_PROD = 5'd23;
  localparam logic [UPC_BITS-1:0] UOP_THR       = 5'd24;

  localparam logic [CFG_IDX_BITS-1:0] CFG_ORIGIN_X  = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_ORIGIN_Y  = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_ORIGIN_Z  = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_DIR_X     = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_DIR_Y     = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] CFG_DIR_Z     = 3'd5;
  localparam logic [CFG_IDX_BITS-1:0] CFG_DET_EPS   = 3'd6;
  localparam logic [CFG_IDX_BITS-1:0] CFG_PARAM_EPS = 3'd7;

  typedef enum logic [3:0] {
    A_E1X, A_E1Y, A_E1Z, A_DX, A_DY, A_DZ,
    A_N0, A_N1, A_N2, A_Q0, A_Q1, A_Q2, A_EPS
  } a_sel_t;

  typedef enum logic [3:0] {
    B_E2X, B_E2Y, B_E2Z, B_DX, B_DY, B_DZ,
    B_SX, B_SY, B_SZ, B_E1X, B_E1Y, B_E1Z, B_DET
  } b_sel_t;

  typedef enum logic [3:0] {
    D_NONE, D_N0, D_N1, D_N2, D_Q0, D_Q1, D_Q2,
    D_DET, D_NT, D_NB, D_NG, D_THR
  } dest_t;

  typedef enum logic [1:0] {DIV_T, DIV_B, DIV_G} div_sel_t;

  typedef struct packed {
    a_sel_t a;
    b_sel_t b;
    logic   neg;
    logic   first;
    dest_t  dest;
  } uop_t;

  typedef struct packed {
    logic     load;
    logic     mul_start;
    uop_t     uop;
    logic     fix;
    logic     div_start;
    div_sel_t div_sel;
    logic     update;
    logic     emit;
  } cmd_t;

  typedef struct packed {
    logic mul_done;
    logic div_done;
    logic ok;
    logic better;
    logic last;
    logic out_free;
  } status_t;

  // Product terms: cross E1xE2, det, N.S, cross DxS, Q.E2, -(Q.E1), then eps*det.
  function automatic uop_t uop_rom(input logic [UPC_BITS-1:0] idx);
    uop_t u;
    unique case (idx)
      5'd0:  u = '{A_E1Y, B_E2Z, 1'b0, 1'b1, D_NONE};
      5'd1:  u = '{A_E1Z, B_E2Y, 1'b1, 1'b0, D_N0};
      5'd2:  u = '{A_E1Z, B_E2X, 1'b0, 1'b1, D_NONE};
      5'd3:  u = '{A_E1X, B_E2Z, 1'b1, 1'b0, D_N1};
      5'd4:  u = '{A_E1X, B_E2Y, 1'b0, 1'b1, D_NONE};
      5'd5:  u = '{A_E1Y, B_E2X, 1'b1, 1'b0, D_N2};
      5'd6:  u = '{A_N0,  B_DX,  1'b0, 1'b1, D_NONE};
      5'd7:  u = '{A_N1,  B_DY,  1'b0, 1'b0, D_NONE};
      5'd8:  u = '{A_N2,  B_DZ,  1'b0, 1'b0, D_DET};
      5'd9:  u = '{A_N0,  B_SX,  1'b0, 1'b1, D_NONE};
      5'd10: u = '{A_N1,  B_SY,  1'b0, 1'b0, D_NONE};
      5'd11: u = '{A_N2,  B_SZ,  1'b0, 1'b0, D_NT};
      5'd12: u = '{A_DY,  B_SZ,  1'b0, 1'b1, D_NONE};
      5'd13: u = '{A_DZ,  B_SY,  1'b1, 1'b0, D_Q0};
      5'd14: u = '{A_DZ,  B_SX,  1'b0, 1'b1, D_NONE};
      5'd15: u = '{A_DX,  B_SZ,  1'b1, 1'b0, D_Q1};
      5'd16: u = '{A_DX,  B_SY,  1'b0, 1'b1, D_NONE};
      5'd17: u = '{A_DY,  B_SX,  1'b1, 1'b0, D_Q2};
      5'd18: u = '{A_Q0,  B_E2X, 1'b0, 1'b1, D_NONE};
      5'd19: u = '{A_Q1,  B_E2Y, 1'b0, 1'b0, D_NONE};
      5'd20: u = '{A_Q2,  B_E2Z, 1'b0, 1'b0, D_NB};
      5'd21: u = '{A_Q0,  B_E1X, 1'b1, 1'b1, D_NONE};
      5'd22: u = '{A_Q1,  B_E1Y, 1'b1, 1'b0, D_NONE};
      5'd23: u = '{A_Q2,  B_E1Z, 1'b1, 1'b0, D_NG};
      5'd24: u = '{A_EPS, B_DET, 1'b0, 1'b1, D_THR};
      default: u = '{A_E1X, B_E2X, 1'b0, 1'b1, D_NONE};
    endcase
    return u;
  endfunction

endpackage

### rtl/ray_triangle_closest_hit_top.sv
// Top level of the closest-hit ray/triangle intersector.
// The ray origin, direction and the two thresholds sit in write-only registers;
// triangles stream in one at a time and the closest accepted hit is reported on
// the triangle flagged last, after which the search restarts for the next ray.
// Each triangle runs 25 product terms on one shared multiplier that takes one
// 16-bit chunk of its second operand per cycle; a hit also runs a 31-step divide
// for t and, when it is the new closest, two 17-step divides for beta and gamma
// and the update.
// The output register holds a result while the next ray's triangles are taken;
// a last triangle waits in its final cycle only while that register is still full.
module ray_triangle_closest_hit_top #(
  parameter int INDEX_BITS = 20,
  parameter int COORD_BITS = 24
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [rtc_pkg::CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [rtc_pkg::CFG_DATA_BITS-1:0] cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [INDEX_BITS-1:0]             in_tri_id,
  input  logic signed [COORD_BITS-1:0]      in_a_x,
  input  logic signed [COORD_BITS-1:0]      in_a_y,
  input  logic signed [COORD_BITS-1:0]      in_a_z,
  input  logic signed [COORD_BITS-1:0]      in_b_x,
  input  logic signed [COORD_BITS-1:0]      in_b_y,
  input  logic signed [COORD_BITS-1:0]      in_b_z,
  input  logic signed [COORD_BITS-1:0]      in_c_x,
  input  logic signed [COORD_BITS-1:0]      in_c_y,
  input  logic signed [COORD_BITS-1:0]      in_c_z,
  input  logic                              in_last_tri,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_hit,
  output logic [INDEX_BITS-1:0]             out_hit_id,
  output logic [rtc_pkg::T_BITS-1:0]        out_hit_t,
  output logic [rtc_pkg::BARY_BITS-1:0]     out_bary_alpha,
  output logic [rtc_pkg::BARY_BITS-1:0]     out_bary_beta,
  output logic [rtc_pkg::BARY_BITS-1:0]     out_bary_gamma
);
  import rtc_pkg::*;

  cmd_t    cmd;
  status_t st;
  logic signed [COORD_BITS-1:0] va [3];
  logic signed [COORD_BITS-1:0] vb [3];
  logic signed [COORD_BITS-1:0] vc [3];

  assign va[0] = in_a_x;
  assign va[1] = in_a_y;
  assign va[2] = in_a_z;
  assign vb[0] = in_b_x;
  assign vb[1] = in_b_y;
  assign vb[2] = in_b_z;
  assign vc[0] = in_c_x;
  assign vc[1] = in_c_y;
  assign vc[2] = in_c_z;

  rtc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .st       (st)
  );

  rtc_datapath #(
    .INDEX_BITS (INDEX_BITS),
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .tri_id         (in_tri_id),
    .va             (va),
    .vb             (vb),
    .vc             (vc),
    .last_tri       (in_last_tri),
    .out_ready      (out_ready),
    .out_valid      (out_valid),
    .out_hit        (out_hit),
    .out_hit_id     (out_hit_id),
    .out_hit_t      (out_hit_t),
    .out_bary_alpha (out_bary_alpha),
    .out_bary_beta  (out_bary_beta),
    .out_bary_gamma (out_bary_gamma),
    .cmd            (cmd),
    .st             (st)
  );

endmodule

### rtl/rtc_ctrl.sv
// Sequencing state machine of the closest-hit intersector.
module rtc_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  output rtc_pkg::cmd_t    cmd,
  input  rtc_pkg::status_t st
);
  import rtc_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE     = 10'b00_0000_0001,
    S_MUL_GO   = 10'b00_0000_0010,
    S_MUL_WAIT = 10'b00_0000_0100,
    S_FIX      = 10'b00_0000_1000,
    S_CHECK    = 10'b00_0001_0000,
    S_DIV_GO   = 10'b00_0010_0000,
    S_DIV_WAIT = 10'b00_0100_0000,
    S_CMP      = 10'b00_1000_0000,
    S_UPDATE   = 10'b01_0000_0000,
    S_FINISH   = 10'b10_0000_0000
  } state_t;

  state_t                state_r, state_nxt;
  logic [UPC_BITS-1:0]   upc_r, upc_nxt;
  div_sel_t              sel_r, sel_nxt;

  always_comb begin
    state_nxt   = state_r;
    upc_nxt     = upc_r;
    sel_nxt     = sel_r;
    cmd         = '0;
    cmd.uop     = uop_rom(upc_r);
    cmd.div_sel = sel_r;
    in_ready    = (state_r == S_IDLE);
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          upc_nxt   = '0;
          state_nxt = S_MUL_GO;
        end
      end
      S_MUL_GO: begin
        cmd.mul_start = 1'b1;
        state_nxt     = S_MUL_WAIT;
      end
      S_MUL_WAIT: begin
        if (st.mul_done) begin
          if (upc_r == UOP_LAST_PROD) begin
            state_nxt = S_FIX;
          end else if (upc_r == UOP_THR) begin
            state_nxt = S_CHECK;
          end else begin
            upc_nxt   = upc_r + 1'b1;
            state_nxt = S_MUL_GO;
          end
        end
      end
      S_FIX: begin
        cmd.fix   = 1'b1;
        upc_nxt   = UOP_THR;
        state_nxt = S_MUL_GO;
      end
      S_CHECK: begin
        if (st.ok) begin
          sel_nxt   = DIV_T;
          state_nxt = S_DIV_GO;
        end else begin
          state_nxt = S_FINISH;
        end
      end
      S_DIV_GO: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (st.div_done) begin
          unique case (sel_r)
            DIV_T: state_nxt = S_CMP;
            DIV_B: begin
              sel_nxt   = DIV_G;
              state_nxt = S_DIV_GO;
            end
            default: state_nxt = S_UPDATE;
          endcase
        end
      end
      S_CMP: begin
        if (st.better) begin
          sel_nxt   = DIV_B;
          state_nxt = S_DIV_GO;
        end else begin
          state_nxt = S_FINISH;
        end
      end
      S_UPDATE: begin
        cmd.update = 1'b1;
        state_nxt  = S_FINISH;
      end
      S_FINISH: begin
        if (!st.last) begin
          state_nxt = S_IDLE;
        end else if (st.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      upc_r   <= '0;
      sel_r   <= DIV_T;
    end else begin
      state_r <= state_nxt;
      upc_r   <= upc_nxt;
      sel_r   <= sel_nxt;
    end
  end

endmodule

### rtl/rtc_datapath.sv
// Ray registers, shared chunked multiplier, restoring divider and closest-hit tracking.
module rtc_datapath #(
  parameter int INDEX_BITS = 20,
  parameter int COORD_BITS = 24
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [rtc_pkg::CFG_IDX_BITS-1:0]     cfg_index,
  input  logic [rtc_pkg::CFG_DATA_BITS-1:0]    cfg_data,
  input  logic [INDEX_BITS-1:0]                tri_id,
  input  logic signed [COORD_BITS-1:0]         va [3],
  input  logic signed [COORD_BITS-1:0]         vb [3],
  input  logic signed [COORD_BITS-1:0]         vc [3],
  input  logic                                 last_tri,
  input  logic                                 out_ready,
  output logic                                 out_valid,
  output logic                                 out_hit,
  output logic [INDEX_BITS-1:0]                out_hit_id,
  output logic [rtc_pkg::T_BITS-1:0]           out_hit_t,
  output logic [rtc_pkg::BARY_BITS-1:0]        out_bary_alpha,
  output logic [rtc_pkg::BARY_BITS-1:0]        out_bary_beta,
  output logic [rtc_pkg::BARY_BITS-1:0]        out_bary_gamma,
  input  rtc_pkg::cmd_t                        cmd,
  output rtc_pkg::status_t                     st
);
  import rtc_pkg::*;

  localparam int C    = COORD_BITS;
  localparam int WE   = C + 1;
  localparam int WA   = 2 * C + 3;
  localparam int WV   = 3 * C + 7;
  localparam int NSM  = (WE + CHUNK_BITS - 1) / CHUNK_BITS;
  localparam int NDET = (WV + CHUNK_BITS - 1) / CHUNK_BITS;
  localparam int WBX  = NDET * CHUNK_BITS;
  localparam int KW   = (NDET > 1) ? $clog2(NDET) : 1;
  localparam int WACC = WA + WBX + 2;
  localparam int WC   = WV + 17;
  localparam int WR   = WV + 32;
  localparam int WK   = ((WV > DET_EPS_BITS) ? WV : DET_EPS_BITS) + 1;
  localparam logic signed [C-1:0] DIR_X_RST = C'(DIR_X_RESET);

  // ray configuration
  logic signed [C-1:0]        orig_r [3];
  logic signed [C-1:0]        dir_r  [3];
  logic [DET_EPS_BITS-1:0]    det_eps_r;
  logic [PARAM_BITS-1:0]      param_eps_r;

  // triangle operands and products
  logic signed [WE-1:0]       e1_r [3];
  logic signed [WE-1:0]       e2_r [3];
  logic signed [WE-1:0]       s_r  [3];
  logic signed [WA-1:0]       n_r  [3];
  logic signed [WA-1:0]       q_r  [3];
  logic signed [WV-1:0]       det_r, nt_r, nb_r, ng_r;
  logic signed [WC-1:0]       thr_r;
  logic [INDEX_BITS-1:0]      id_r;
  logic                       last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 3; k++) begin
        orig_r[k] <= '0;
      end
      dir_r[0]    <= DIR_X_RST;
      dir_r[1]    <= '0;
      dir_r[2]    <= '0;
      det_eps_r   <= DET_EPS_BITS'(1);
      param_eps_r <= PARAM_BITS'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ORIGIN_X:  orig_r[0]   <= cfg_data[C-1:0];
        CFG_ORIGIN_Y:  orig_r[1]   <= cfg_data[C-1:0];
        CFG_ORIGIN_Z:  orig_r[2]   <= cfg_data[C-1:0];
        CFG_DIR_X:     dir_r[0]    <= cfg_data[C-1:0];
        CFG_DIR_Y:     dir_r[1]    <= cfg_data[C-1:0];
        CFG_DIR_Z:     dir_r[2]    <= cfg_data[C-1:0];
        CFG_DET_EPS:   det_eps_r   <= cfg_data[DET_EPS_BITS-1:0];
        CFG_PARAM_EPS: param_eps_r <= cfg_data[PARAM_BITS-1:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      for (int k = 0; k < 3; k++) begin
        e1_r[k] <= WE'(va[k]) - WE'(vb[k]);
        e2_r[k] <= WE'(va[k]) - WE'(vc[k]);
        s_r[k]  <= WE'(va[k]) - WE'(orig_r[k]);
      end
      id_r   <= tri_id;
      last_r <= last_tri;
    end
  end

  // operand pools
  logic signed [WA-1:0] a_pick;
  logic signed [WBX-1:0] b_pick;

  always_comb begin
    unique case (cmd.uop.a)
      A_E1X:   a_pick = WA'(e1_r[0]);
      A_E1Y:   a_pick = WA'(e1_r[1]);
      A_E1Z:   a_pick = WA'(e1_r[2]);
      A_DX:    a_pick = WA'(dir_r[0]);
      A_DY:    a_pick = WA'(dir_r[1]);
      A_DZ:    a_pick = WA'(dir_r[2]);
      A_N0:    a_pick = n_r[0];
      A_N1:    a_pick = n_r[1];
      A_N2:    a_pick = n_r[2];
      A_Q0:    a_pick = q_r[0];
      A_Q1:    a_pick = q_r[1];
      A_Q2:    a_pick = q_r[2];
      A_EPS:   a_pick = $signed(WA'(param_eps_r));
      default: a_pick = '0;
    endcase
    unique case (cmd.uop.b)
      B_E2X:   b_pick = WBX'(e2_r[0]);
      B_E2Y:   b_pick = WBX'(e2_r[1]);
      B_E2Z:   b_pick = WBX'(e2_r[2]);
      B_DX:    b_pick = WBX'(dir_r[0]);
      B_DY:    b_pick = WBX'(dir_r[1]);
      B_DZ:    b_pick = WBX'(dir_r[2]);
      B_SX:    b_pick = WBX'(s_r[0]);
      B_SY:    b_pick = WBX'(s_r[1]);
      B_SZ:    b_pick = WBX'(s_r[2]);
      B_E1X:   b_pick = WBX'(e1_r[0]);
      B_E1Y:   b_pick = WBX'(e1_r[1]);
      B_E1Z:   b_pick = WBX'(e1_r[2]);
      B_DET:   b_pick = WBX'(det_r);
      default: b_pick = '0;
    endcase
  end

  // shared multiplier: one 16-bit chunk of B per cycle, top chunk signed
  logic signed [WA-1:0]    ma_r;
  logic [WBX-1:0]          mb_r;
  logic [KW-1:0]           mk_r, mkmax_r;
  logic                    mneg_r, mbusy_r;
  dest_t                   mdest_r;
  logic signed [WACC-1:0]  acc_r;
  logic [CHUNK_BITS-1:0]   chunk;
  logic                    mtop;
  logic signed [CHUNK_BITS:0] cx;
  logic signed [WA+CHUNK_BITS:0] pp;
  logic signed [WACC-1:0]  pp_sh, acc_new;
  logic                    mul_done;

  always_comb begin
    chunk    = mb_r[mk_r*CHUNK_BITS +: CHUNK_BITS];
    mtop     = (mk_r == mkmax_r);
    cx       = $signed({mtop & chunk[CHUNK_BITS-1], chunk});
    pp       = ma_r * cx;
    pp_sh    = WACC'(pp) << (CHUNK_BITS * mk_r);
    acc_new  = mneg_r ? (acc_r - pp_sh) : (acc_r + pp_sh);
    mul_done = mbusy_r && mtop;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mbusy_r <= 1'b0;
    end else if (cmd.mul_start) begin
      mbusy_r <= 1'b1;
    end else if (mul_done) begin
      mbusy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_start) begin
      ma_r    <= a_pick;
      mb_r    <= b_pick;
      mk_r    <= '0;
      mkmax_r <= (cmd.uop.b == B_DET) ? KW'(NDET - 1) : KW'(NSM - 1);
      mneg_r  <= cmd.uop.neg;
      mdest_r <= cmd.uop.dest;
      if (cmd.uop.first) begin
        acc_r <= '0;
      end
    end else if (mbusy_r) begin
      acc_r <= acc_new;
      mk_r  <= mk_r + 1'b1;
    end
  end

  // write back finished sums; flip signs so that det is nonnegative
  always_ff @(posedge clk) begin
    if (mul_done) begin
      unique case (mdest_r)
        D_N0:    n_r[0] <= WA'(acc_new);
        D_N1:    n_r[1] <= WA'(acc_new);
        D_N2:    n_r[2] <= WA'(acc_new);
        D_Q0:    q_r[0] <= WA'(acc_new);
        D_Q1:    q_r[1] <= WA'(acc_new);
        D_Q2:    q_r[2] <= WA'(acc_new);
        D_DET:   det_r  <= WV'(acc_new);
        D_NT:    nt_r   <= WV'(acc_new);
        D_NB:    nb_r   <= WV'(acc_new);
        D_NG:    ng_r   <= WV'(acc_new);
        D_THR:   thr_r  <= WC'(acc_new);
        default: ;
      endcase
    end else if (cmd.fix && det_r[WV-1]) begin
      det_r <= -det_r;
      nt_r  <= -nt_r;
      nb_r  <= -nb_r;
      ng_r  <= -ng_r;
    end
  end

  // acceptance tests
  logic signed [WK-1:0] det_k, eps_k;
  logic signed [WC-1:0] nt_sh, nb_sh, ng_sh;
  logic signed [WV:0]   sum_bg, det_w;
  logic                 hit_ok;

  always_comb begin
    det_k  = WK'(det_r);
    eps_k  = $signed(WK'(det_eps_r));
    nt_sh  = WC'($signed({nt_r, 16'h0}));
    nb_sh  = WC'($signed({nb_r, 16'h0}));
    ng_sh  = WC'($signed({ng_r, 16'h0}));
    sum_bg = (WV+1)'(nb_r) + (WV+1)'(ng_r);
    det_w  = (WV+1)'(det_r);
    hit_ok = (eps_k < det_k) && (thr_r < nt_sh)
          && (thr_r < nb_sh) && !(det_r < nb_r)
          && (thr_r < ng_sh) && !(det_w < sum_bg);
  end

  // restoring divider, one quotient bit per cycle
  logic [WR-1:0]        dv_rem_r, dv_den_r;
  logic [T_BITS-1:0]    dv_q_r, dv_q_nxt;
  logic [4:0]           dv_cnt_r;
  logic                 dv_busy_r, sat_r, dv_ge, div_done;
  div_sel_t             dv_sel_r;
  logic [T_BITS-1:0]    tv_r;
  logic [BARY_BITS-1:0] bq_r, gq_r;
  logic [WV+15:0]       sat_lhs, sat_rhs;

  always_comb begin
    dv_ge    = (dv_rem_r >= dv_den_r);
    dv_q_nxt = {dv_q_r[T_BITS-2:0], dv_ge};
    div_done = dv_busy_r && (dv_cnt_r == '0);
    sat_lhs  = (WV+16)'($unsigned(nt_r));
    sat_rhs  = (WV+16)'($unsigned(det_r)) << 15;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_busy_r <= 1'b0;
    end else if (cmd.div_start) begin
      dv_busy_r <= 1'b1;
    end else if (div_done) begin
      dv_busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      dv_sel_r <= cmd.div_sel;
      dv_q_r   <= '0;
      sat_r    <= (sat_lhs >= sat_rhs);
      unique case (cmd.div_sel)
        DIV_T: begin
          dv_rem_r <= WR'({nt_r, 16'h0});
          dv_den_r <= WR'($unsigned(det_r)) << (DIV_STEPS_T - 1);
          dv_cnt_r <= 5'(DIV_STEPS_T - 1);
        end
        DIV_B: begin
          dv_rem_r <= WR'({nb_r, 16'h0});
          dv_den_r <= WR'($unsigned(det_r)) << (DIV_STEPS_BARY - 1);
          dv_cnt_r <= 5'(DIV_STEPS_BARY - 1);
        end
        default: begin
          dv_rem_r <= WR'({ng_r, 16'h0});
          dv_den_r <= WR'($unsigned(det_r)) << (DIV_STEPS_BARY - 1);
          dv_cnt_r <= 5'(DIV_STEPS_BARY - 1);
        end
      endcase
    end else if (dv_busy_r) begin
      if (dv_ge) begin
        dv_rem_r <= dv_rem_r - dv_den_r;
      end
      dv_den_r <= dv_den_r >> 1;
      dv_q_r   <= dv_q_nxt;
      dv_cnt_r <= dv_cnt_r - 1'b1;
      if (div_done) begin
        unique case (dv_sel_r)
          DIV_T:   tv_r <= sat_r ? T_MAX : dv_q_nxt;
          DIV_B:   bq_r <= dv_q_nxt[BARY_BITS-1:0];
          default: gq_r <= dv_q_nxt[BARY_BITS-1:0];
        endcase
      end
    end
  end

  // closest hit so far
  logic                  best_valid_r;
  logic [T_BITS-1:0]     best_t_r;
  logic [INDEX_BITS-1:0] best_id_r;
  logic [BARY_BITS-1:0]  best_alpha_r, best_beta_r, best_gamma_r;

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.emit) begin
      best_valid_r <= 1'b0;
      best_t_r     <= '0;
      best_id_r    <= '0;
      best_alpha_r <= '0;
      best_beta_r  <= '0;
      best_gamma_r <= '0;
    end else if (cmd.update) begin
      best_valid_r <= 1'b1;
      best_t_r     <= tv_r;
      best_id_r    <= id_r;
      best_alpha_r <= ONE_Q16 - bq_r - gq_r;
      best_beta_r  <= bq_r;
      best_gamma_r <= gq_r;
    end
  end

  // output register: holds one result while the next triangle runs
  logic out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_hit        <= best_valid_r;
      out_hit_id     <= best_id_r;
      out_hit_t      <= best_t_r;
      out_bary_alpha <= best_alpha_r;
      out_bary_beta  <= best_beta_r;
      out_bary_gamma <= best_gamma_r;
    end
  end

  assign out_valid = out_valid_r;

  always_comb begin
    st.mul_done = mul_done;
    st.div_done = div_done;
    st.ok       = hit_ok;
    st.better   = !best_valid_r || (tv_r < best_t_r);
    st.last     = last_r;
    st.out_free = !out_valid_r || out_ready;
  end

  a_mul_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mul_start |-> !mbusy_r && !dv_busy_r)
    else $error("multiply started while a unit is busy");

  a_div_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |-> !mbusy_r && !dv_busy_r)
    else $error("divide started while a unit is busy");

  a_emit_clears: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> out_valid_r && !best_valid_r)
    else $error("result emit did not load output and clear search");

  a_update_sets: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.update |=> best_valid_r && (best_t_r == $past(tv_r)))
    else $error("closest hit not recorded");

endmodule
